FILE: rtl/bn254_alu_pkg.sv
`timescale 1ns / 1ps
package bn254_alu_pkg;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_NEG   = 3'd2,
    OP_MUL   = 3'd3,
    OP_SCALE = 3'd4,
    OP_MAC   = 3'd5,
    OP_FOLD  = 3'd6,
    OP_NONE  = 3'd7
  } op_e;

  localparam int unsigned NumLimbs = 4;
  // pipeline depth of one Montgomery cell
  localparam int unsigned CellStages = 8;
  // partial product rows out of one multiplier cell
  localparam int unsigned MulRows = 4;

  typedef logic [63:0] limb_t;
  typedef logic [255:0] elem_t;

  localparam elem_t ModP = 256'h30644e72e131a029b85045b68181585d2833e84879b9709143e1f593f0000001;
  localparam limb_t MontNinv = 64'hc2e1f593efffffff;

  // Item context carried alongside the data through the chain
  typedef struct packed {
    logic  vld;
    op_e   op;
    logic  last;
    elem_t a;
    elem_t b;
  } ctx_t;

  // Modular add following the carry / no-borrow rule
  function automatic elem_t fadd(elem_t x, elem_t y);
    logic [256:0] s;
    logic [256:0] d;
    s = {1'b0, x} + {1'b0, y};
    d = {1'b0, s[255:0]} - {1'b0, ModP};
    fadd = (s[256] || !d[256]) ? d[255:0] : s[255:0];
  endfunction

  // Modular subtract: add p back on borrow
  function automatic elem_t fsub(elem_t x, elem_t y);
    logic [256:0] d;
    d = {1'b0, x} - {1'b0, y};
    fsub = d[256] ? (d[255:0] + ModP) : d[255:0];
  endfunction

endpackage

FILE: rtl/bn254_alu_mul_cell.sv
`timescale 1ns / 1ps
// Partial products of a 64-bit word and a 256-bit operand, built from
// 32x32 multipliers and registered as four rows that sum to x*y.
module bn254_alu_mul_cell (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [63:0]   x_i,
  input  logic [255:0]  y_i,
  output logic [319:0]  row_o [bn254_alu_pkg::MulRows]
);
  import bn254_alu_pkg::*;

  logic [319:0] row_d [MulRows];
  logic [319:0] row_q [MulRows];

  // row 2*h+parity: x half h times the even or odd y halves, no overlap
  always_comb begin
    for (int r = 0; r < MulRows; r++) row_d[r] = '0;
    for (int h = 0; h < 2; h++) begin
      for (int k = 0; k < 8; k++) begin
        row_d[2*h + (k & 1)][32*(h+k) +: 64] =
          64'(x_i[32*h +: 32]) * 64'(y_i[32*k +: 32]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < MulRows; r++) row_q[r] <= row_d[r];
    end
  end

  assign row_o = row_q;
endmodule

FILE: rtl/bn254_alu_mont_cell.sv
`timescale 1ns / 1ps
// One Montgomery pass cell: t += x_i*y, then reduce by one limb.
// Work is split over eight stages; the pass is held in registers between them.
module bn254_alu_mont_cell
  import bn254_alu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  bn254_alu_pkg::ctx_t ctx_i,
  input  logic [63:0]         x_i,
  input  logic [255:0]        y_i,
  input  logic [255:0]        t_i,
  input  logic [255:0]        x_rest_i,
  output bn254_alu_pkg::ctx_t ctx_o,
  output logic [255:0]        t_o,
  output logic [255:0]        x_rest_o
);
  ctx_t         ctx_q [CellStages];
  logic [255:0] xr_q  [CellStages];
  // stage 1: x*y rows and incoming t
  logic [319:0] xy_row [MulRows];
  logic [255:0] t1_q;
  // stage 2: two partial sums
  logic [319:0] u2_q, v2_q;
  // stage 3: five-limb accumulator
  logic [319:0] acc3_q;
  // stage 4: pieces of m = acc0 * ninv mod 2^64
  logic [63:0]  q0_q;
  logic [31:0]  q1_q, q2_q;
  logic [319:0] acc4_q;
  // stage 5: m
  logic [63:0]  m5_q;
  logic [319:0] acc5_q;
  // stage 6: m*p rows
  logic [319:0] mp_row [MulRows];
  logic [319:0] acc6_q;
  // stage 7: low limbs plus m*p as two partial sums
  logic [319:0] w1_q, w2_q;
  logic [63:0]  top7_q;
  // stage 8: reduced and shifted t
  logic [319:0] red_d;
  logic [255:0] t8_q;

  bn254_alu_mul_cell u_mul_xy (
    .clk_i,
    .en_i,
    .x_i   (x_i),
    .y_i   (y_i),
    .row_o (xy_row)
  );

  bn254_alu_mul_cell u_mul_mp (
    .clk_i,
    .en_i,
    .x_i   (m5_q),
    .y_i   (ModP),
    .row_o (mp_row)
  );

  // low limbs plus m*p; the sum stays below 2^320
  assign red_d = w1_q + w2_q;

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q   <= t_i;
      u2_q   <= xy_row[0] + xy_row[1] + {64'd0, t1_q};
      v2_q   <= xy_row[2] + xy_row[3];
      acc3_q <= u2_q + v2_q;
      q0_q   <= 64'(acc3_q[31:0]) * 64'(MontNinv[31:0]);
      q1_q   <= acc3_q[31:0] * MontNinv[63:32];
      q2_q   <= acc3_q[63:32] * MontNinv[31:0];
      acc4_q <= acc3_q;
      m5_q   <= q0_q + {q1_q + q2_q, 32'd0};
      acc5_q <= acc4_q;
      acc6_q <= acc5_q;
      w1_q   <= {64'd0, acc6_q[255:0]} + mp_row[0] + mp_row[1];
      w2_q   <= mp_row[2] + mp_row[3];
      top7_q <= acc6_q[319:256];
      // top limb wraps at 64 bits as the limb rule demands
      t8_q   <= {top7_q + red_d[319:256], red_d[255:64]};
    end
  end

  // remaining x limbs ride along
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xr_q[0] <= x_rest_i;
      for (int s = 1; s < CellStages; s++) xr_q[s] <= xr_q[s-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < CellStages; s++) ctx_q[s] <= '0;
    end else if (en_i) begin
      ctx_q[0] <= ctx_i;
      for (int s = 1; s < CellStages; s++) ctx_q[s] <= ctx_q[s-1];
    end
  end

  assign ctx_o    = ctx_q[CellStages-1];
  assign t_o      = t8_q;
  assign x_rest_o = xr_q[CellStages-1];
endmodule

FILE: rtl/bn254_scalar_field_alu.sv
`timescale 1ns / 1ps
// Structure: an input register that loads at the accepting edge, then
// 4 Montgomery cells of 8 stages each, a correction stage and an output
// register.
// Throughput: one request per cycle; the whole chain advances when the
// output register is free or being drained, otherwise every stage holds.
// Reset: asynchronous active low; clears valids, item context and scalar.
module bn254_scalar_field_alu
  import bn254_alu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation_i,
  input  logic [63:0] a_limb0_i,
  input  logic [63:0] a_limb1_i,
  input  logic [63:0] a_limb2_i,
  input  logic [63:0] a_limb3_i,
  input  logic [63:0] b_limb0_i,
  input  logic [63:0] b_limb1_i,
  input  logic [63:0] b_limb2_i,
  input  logic [63:0] b_limb3_i,
  input  logic        last_in_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] r_limb0_o,
  output logic [63:0] r_limb1_o,
  output logic [63:0] r_limb2_o,
  output logic [63:0] r_limb3_o,
  output logic        last_out_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  logic [63:0] s_q [NumLimbs];
  elem_t       s_full;
  logic        adv;
  ctx_t        ctx0_q;
  elem_t       x0_q, y0_q;
  ctx_t        ctx_c [NumLimbs+1];
  elem_t       t_c   [NumLimbs+1];
  elem_t       xr_c  [NumLimbs+1];
  elem_t       y_c   [NumLimbs+1];
  elem_t       a_in, b_in, x_d, y_d;
  ctx_t        ctx_d;
  elem_t       mres_d, r_d;
  logic [256:0] msub;
  ctx_t        pc_q;
  elem_t       mres_q;
  logic        ov_q, last_q;
  elem_t       r_q;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumLimbs; i++) s_q[i] <= '0;
    end else if (cfg_valid) begin
      s_q[cfg_index_i] <= cfg_data_i;
    end
  end
  assign s_full = {s_q[3], s_q[2], s_q[1], s_q[0]};

  // chain moves unless a finished result is blocked
  assign adv      = !ov_q || !out_stall;
  assign in_stall = !adv;

  assign a_in = {a_limb3_i, a_limb2_i, a_limb1_i, a_limb0_i};
  assign b_in = {b_limb3_i, b_limb2_i, b_limb1_i, b_limb0_i};

  // operand selection for the multiplier chain
  always_comb begin
    ctx_d.vld  = in_valid;
    ctx_d.op   = op_e'(operation_i);
    ctx_d.last = last_in_i;
    ctx_d.a    = a_in;
    ctx_d.b    = b_in;
    x_d = a_in;
    y_d = b_in;
    case (op_e'(operation_i)) inside
      OP_SCALE, OP_MAC: y_d = s_full;
      OP_FOLD: begin
        x_d = s_full;
        y_d = fsub(b_in, a_in);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx0_q <= '0;
    end else if (adv) begin
      ctx0_q <= ctx_d;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x0_q <= x_d;
      y0_q <= y_d;
    end
  end

  assign ctx_c[0] = ctx0_q;
  assign t_c[0]   = '0;
  assign xr_c[0]  = x0_q;
  assign y_c[0]   = y0_q;

  // y operand delayed alongside each cell
  for (genvar i = 0; i < NumLimbs; i++) begin : g_cell
    logic [255:0] yd_q [CellStages];
    bn254_alu_mont_cell u_cell (
      .clk_i,
      .rst_ni,
      .en_i     (adv),
      .ctx_i    (ctx_c[i]),
      .x_i      (xr_c[i][63:0]),
      .y_i      (y_c[i]),
      .t_i      (t_c[i]),
      .x_rest_i ({64'd0, xr_c[i][255:64]}),
      .ctx_o    (ctx_c[i+1]),
      .t_o      (t_c[i+1]),
      .x_rest_o (xr_c[i+1])
    );
    always_ff @(posedge clk_i) begin
      if (adv) begin
        yd_q[0] <= y_c[i];
        for (int k = 1; k < CellStages; k++) yd_q[k] <= yd_q[k-1];
      end
    end
    assign y_c[i+1] = yd_q[CellStages-1];
  end

  // final correction of the product, registered
  assign msub = {1'b0, t_c[NumLimbs]} - {1'b0, ModP};
  assign mres_d = msub[256] ? t_c[NumLimbs] : msub[255:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else if (adv) begin
      pc_q <= ctx_c[NumLimbs];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mres_q <= mres_d;
    end
  end

  // post op
  always_comb begin
    unique case (pc_q.op) inside
      OP_ADD:   r_d = fadd(pc_q.a, pc_q.b);
      OP_SUB:   r_d = fsub(pc_q.a, pc_q.b);
      OP_NEG:   r_d = (pc_q.a == '0) ? '0 : (ModP - pc_q.a);
      OP_MUL, OP_SCALE: r_d = mres_q;
      OP_MAC:   r_d = fadd(mres_q, pc_q.b);
      OP_FOLD:  r_d = fadd(pc_q.a, mres_q);
      default:  r_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (adv) ov_q <= pc_q.vld;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_q    <= r_d;
      last_q <= pc_q.last;
    end
  end

  assign out_valid  = ov_q;
  assign r_limb0_o  = r_q[63:0];
  assign r_limb1_o  = r_q[127:64];
  assign r_limb2_o  = r_q[191:128];
  assign r_limb3_o  = r_q[255:192];
  assign last_out_o = last_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(r_q))
    else $error("result changed while stalled");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");
  a_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(ctx0_q.vld))
    else $error("chain moved while frozen");
endmodule
